// ----- src/lpr_pkg.sv -----
package lpr_pkg;

  localparam int NUM_FRAMES = 16;
  localparam int IDX_W      = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int OCC_W      = $clog2(NUM_FRAMES + 1);
  localparam int PAGE_W     = 52;
  localparam int STAMP_W    = 48;
  localparam int CFG_W      = 5;

  // request travelling down the cell chain
  typedef struct packed {
    logic               valid;
    logic [PAGE_W-1:0]  page;
    logic               found;
    logic [IDX_W-1:0]   found_idx;
    logic [STAMP_W-1:0] min_stamp;
    logic [IDX_W-1:0]   min_idx;
  } lpr_token_t;

  // frame update broadcast to every cell
  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   idx;
    logic [PAGE_W-1:0]  page;
    logic [STAMP_W-1:0] stamp;
  } lpr_wr_t;

  // fill level and usable frame count; user must keep them stable while a request is in flight (not enforced)
  typedef struct packed {
    logic [OCC_W-1:0] occupancy;
    logic [OCC_W-1:0] cap;
  } lpr_ctl_t;

endpackage

// ----- src/lpr_cell.sv -----
module lpr_cell import lpr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] cell_idx_i,
  input  lpr_ctl_t         ctl_i,
  input  lpr_wr_t          wr_i,
  input  lpr_token_t       tok_i,
  output lpr_token_t       tok_o
);

  logic [PAGE_W-1:0]  page_q;
  logic [STAMP_W-1:0] stamp_q;
  lpr_token_t         tok_d;
  lpr_token_t         tok_q;
  logic               valid_q;
  logic               occupied;
  logic               candidate;

  assign occupied  = OCC_W'(cell_idx_i) < ctl_i.occupancy;
  assign candidate = OCC_W'(cell_idx_i) < ctl_i.cap;

  always_comb begin
    tok_d = tok_i;
    // lowest matching frame wins, so an earlier hit is kept
    if (!tok_i.found && occupied && (page_q == tok_i.page)) begin
      tok_d.found     = 1'b1;
      tok_d.found_idx = cell_idx_i;
    end
    // strict compare keeps the lower index on equal stamps
    if (candidate && ((cell_idx_i == '0) || (stamp_q < tok_i.min_stamp))) begin
      tok_d.min_stamp = stamp_q;
      tok_d.min_idx   = cell_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= tok_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
    if (wr_i.we && (wr_i.idx == cell_idx_i)) begin
      page_q  <= wr_i.page;
      stamp_q <= wr_i.stamp;
    end
  end

  // valid comes from the reset flop, the rest of the request from the payload flops
  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = valid_q;
  end

endmodule

// ----- src/lru_page_replacement_core.sv -----
// lru page replacement, one frame per cell in a chain of NUM_FRAMES cells
// the request is registered in each cell in turn, then in the result registers
// one request at a time: busy is high from accept until the request leaves the chain
// reset: asynchronous, active low; clears fill level, time and fault counters,
//   frames_in_use returns to 16; frame contents stay undefined until written
// results are shown for one cycle only, the receiver cannot stall them
module lru_page_replacement_core import lpr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request side
  input  logic                start,
  output logic                busy,
  input  logic [PAGE_W-1:0]   page_number_i,
  // result side
  output logic                result_valid_o,
  output logic                hit_o,
  output logic [3:0]          frame_index_o,
  output logic                evicted_o,
  output logic [STAMP_W-1:0]  fault_count_o,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam logic [2:0] ADDR_FRAMES_IN_USE = 3'd0;

  // configuration register
  logic [CFG_W-1:0] frames_in_use_q, frames_in_use_d;
  logic             cfg_we;

  // control state
  logic               busy_q, busy_d;
  logic [OCC_W-1:0]   occ_q, occ_d;
  logic [STAMP_W-1:0] time_q, time_d;
  logic [STAMP_W-1:0] fault_q, fault_d;

  // result registers
  logic               res_valid_q, res_valid_d;
  logic               hit_q, hit_d;
  logic [3:0]         frame_q, frame_d;
  logic               evict_q, evict_d;

  logic [OCC_W-1:0]   cap;
  logic [31:0]        cap_wide;
  logic               accept;
  logic               full;
  logic [IDX_W-1:0]   frame_sel;
  logic [31:0]        frame_wide;
  lpr_ctl_t           ctl;
  lpr_wr_t            wr;
  lpr_token_t         tok [NUM_FRAMES+1];
  lpr_token_t         tok_end;

  // apb: no wait states, register decoded on the word address bit
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == ADDR_FRAMES_IN_USE[2]);
  assign prdata = (paddr[2] == ADDR_FRAMES_IN_USE[2]) ? 32'(frames_in_use_q) : '0;
  assign frames_in_use_d = cfg_we ? pwdata[CFG_W-1:0] : frames_in_use_q;

  // usable frames: zero reads as one, saturate at the frame count
  always_comb begin
    if (frames_in_use_q == '0) begin
      cap_wide = 32'd1;
    end else if (32'(frames_in_use_q) > 32'(NUM_FRAMES)) begin
      cap_wide = 32'(NUM_FRAMES);
    end else begin
      cap_wide = 32'(frames_in_use_q);
    end
  end
  assign cap = cap_wide[OCC_W-1:0];

  assign busy   = busy_q;
  assign accept = start && !busy_q;

  assign ctl.occupancy = occ_q;
  assign ctl.cap       = cap;

  // head of the chain: a fresh request with nothing found yet
  always_comb begin
    tok[0]           = '0;
    tok[0].valid     = accept;
    tok[0].page      = page_number_i;
  end

  for (genvar g = 0; g < NUM_FRAMES; g++) begin : g_cell
    lpr_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IDX_W'(g)),
      .ctl_i      (ctl),
      .wr_i       (wr),
      .tok_i      (tok[g]),
      .tok_o      (tok[g+1])
    );
  end

  assign tok_end = tok[NUM_FRAMES];

  // tail of the chain: pick the frame, update counters and the chosen cell
  assign full = !(occ_q < cap);

  always_comb begin
    if (tok_end.found) begin
      frame_sel = tok_end.found_idx;
    end else if (full) begin
      frame_sel = tok_end.min_idx;
    end else begin
      frame_sel = occ_q[IDX_W-1:0];
    end
  end

  assign frame_wide = 32'(frame_sel);

  // hit rewrites the same page, so page and stamp go back on every request
  assign wr.we    = tok_end.valid;
  assign wr.idx   = frame_sel;
  assign wr.page  = tok_end.page;
  assign wr.stamp = time_q;

  always_comb begin
    busy_d      = busy_q;
    occ_d       = occ_q;
    time_d      = time_q;
    fault_d     = fault_q;
    res_valid_d = tok_end.valid;
    hit_d       = hit_q;
    frame_d     = frame_q;
    evict_d     = evict_q;
    if (accept) begin
      busy_d = 1'b1;
    end
    if (tok_end.valid) begin
      busy_d  = 1'b0;
      time_d  = time_q + 1'b1;
      hit_d   = tok_end.found;
      frame_d = frame_wide[3:0];
      evict_d = !tok_end.found && full;
      if (!tok_end.found) begin
        fault_d = fault_q + 1'b1;
        if (!full) begin
          occ_d = occ_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_in_use_q <= CFG_W'(16);
      busy_q          <= 1'b0;
      occ_q           <= '0;
      time_q          <= '0;
      fault_q         <= '0;
      res_valid_q     <= 1'b0;
    end else begin
      frames_in_use_q <= frames_in_use_d;
      busy_q          <= busy_d;
      occ_q           <= occ_d;
      time_q          <= time_d;
      fault_q         <= fault_d;
      res_valid_q     <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q   <= hit_d;
    frame_q <= frame_d;
    evict_q <= evict_d;
  end

  assign result_valid_o = res_valid_q;
  assign hit_o          = hit_q;
  assign frame_index_o  = frame_q;
  assign evicted_o      = evict_q;
  assign fault_count_o  = fault_q;

endmodule
